[rtl/sdo_expedited_client_assert.svh]
// assertion macros used by the checker file
// depends on nothing; take in by include where assertions are written
`ifndef SDO_EXPEDITED_CLIENT_ASSERT_SVH
`define SDO_EXPEDITED_CLIENT_ASSERT_SVH

// implication checked only outside reset
`define SDOC_ASSERT_RUN(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked also across reset
`define SDOC_ASSERT_NEXT(label, clock, ante, cons, msg) \
  label: assert property (@(posedge clock) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sdoc_pkg.sv]
// types and constants of the expedited sdo client
// used by the top level and by its checker; no dependencies
package sdoc_pkg;

  // can identifier bases
  localparam logic [10:0] REQ_BASE  = 11'h600;
  localparam logic [10:0] RSP_BASE  = 11'h580;
  localparam logic [10:0] EMCY_BASE = 11'h080;

  // configuration register reset values and the tick count limit
  localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
  localparam logic [2:0]  ATTEMPTS_RESET = 3'd5;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPTS = 1'b1;

  // input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;
  localparam logic [1:0] KIND_EMCY = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  node_id;
    logic [7:0]  command_byte;
    logic [15:0] object_index;
    logic [7:0]  object_subindex;
    logic [31:0] write_value;
    logic [10:0] rx_identifier;
    logic [63:0] rx_payload;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [10:0] frame_identifier;
    logic [63:0] frame_payload;
    logic [31:0] response_value;
    logic [15:0] emergency_code;
    logic        last_of_run;
  } result_t;

endpackage

[rtl/sdo_expedited_client.sv]
// expedited sdo client engine, top level
// depends on sdoc_pkg for the beat structs and constants
//
// usage
//   item channel (item_valid / item_ready / item): one beat per start request,
//   received can frame or millisecond tick. the transaction state updates at
//   the taking edge, so a new beat can be taken each cycle item_ready is high.
//   result channel (result_valid / result_ready / result): transmit, success,
//   failure and emergency report beats in order; last_of_run marks the final
//   beat caused by one item. an item makes zero, one or two result beats.
//   a result beat enters the output queue at the edge its item is taken.
//   throughput: one item per cycle while results drain and item_ready is high;
//   an emergency that exhausts the attempts gives two beats.
//   results go through a four-entry output queue; item_ready drops while fewer
//   than two entries are free, so a stalled receiver backs up into the sender
//   without losing or repeating beats.
//   configuration (cfg_we / cfg_index / cfg_data) writes the response timeout
//   (index 0) and the attempt limit (index 1); write only while idle.
//   reset (rst, synchronous): engine idle, queue empty, timeout 2000 ticks,
//   attempt limit 5.
module sdo_expedited_client
  import sdoc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result
);

  // configuration registers
  logic [15:0] response_timeout;
  logic [2:0]  max_attempts;

  // transaction state
  logic        busy, busy_next;
  logic [6:0]  pending_node, pending_node_next;
  logic [15:0] pending_index, pending_index_next;
  logic [2:0]  attempts_used, attempts_used_next;
  logic [15:0] tick_count, tick_count_next;
  logic [63:0] last_response, last_response_next;

  // output queue
  result_t     queue [4];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  count, count_next;

  // results produced by the current beat
  result_t     res0, res1;
  logic [1:0]  n_res;

  logic        accept, pop;
  logic [2:0]  att_inc;
  logic        exhausted;
  logic [63:0] fail_src, fail_pay;
  logic [15:0] tick_sat;
  logic [10:0] rsp_id, emcy_id;
  result_t     fail_res;

  assign accept       = item_valid && item_ready;
  assign pop          = result_valid && result_ready;
  assign item_ready   = (count <= 3'd2);
  assign result_valid = (count != 3'd0);
  assign result       = queue[rd_ptr];

  assign rsp_id   = RSP_BASE + {4'd0, pending_node};
  assign emcy_id  = EMCY_BASE + {4'd0, pending_node};
  assign att_inc  = attempts_used + 3'd1;
  // a zero limit behaves like one: the first used attempt already fails
  assign exhausted = (att_inc >= max_attempts);
  assign tick_sat  = (tick_count == TICK_MAX) ? tick_count : tick_count + 16'd1;

  // a freshly arrived response frame is the failure payload, low byte cleared
  assign fail_src = (item.opcode == OP_FRAME && item.rx_identifier == rsp_id) ?
                    item.rx_payload : last_response;
  assign fail_pay = {fail_src[63:8], 8'h00};

  always_comb begin
    fail_res                  = '0;
    fail_res.result_kind      = KIND_FAIL;
    fail_res.frame_payload    = fail_pay;
    fail_res.response_value   = fail_pay[63:32];
    fail_res.last_of_run      = 1'b1;
  end

  // next state and results of the beat on the item port
  always_comb begin
    busy_next          = busy;
    pending_node_next  = pending_node;
    pending_index_next = pending_index;
    attempts_used_next = attempts_used;
    tick_count_next    = tick_count;
    last_response_next = last_response;
    res0               = '0;
    res1               = '0;
    n_res              = 2'd0;

    unique case (item.opcode)
      OP_START: begin
        // starts while busy are dropped
        if (!busy) begin
          busy_next              = 1'b1;
          pending_node_next      = item.node_id;
          pending_index_next     = item.object_index;
          attempts_used_next     = 3'd0;
          tick_count_next        = 16'd0;
          last_response_next     = 64'd0;
          res0.result_kind       = KIND_TX;
          res0.frame_identifier  = REQ_BASE + {4'd0, item.node_id};
          res0.frame_payload     = {item.write_value, item.object_subindex,
                                    item.object_index, item.command_byte};
          res0.last_of_run       = 1'b1;
          n_res                  = 2'd1;
        end
      end
      OP_FRAME: begin
        if (busy) begin
          priority if (item.rx_identifier == rsp_id) begin
            last_response_next = item.rx_payload;
            if (item.rx_payload[23:8] == pending_index) begin
              // matching response completes the transaction
              busy_next           = 1'b0;
              tick_count_next     = 16'd0;
              res0.result_kind    = KIND_OK;
              res0.frame_payload  = item.rx_payload;
              res0.response_value = item.rx_payload[63:32];
              res0.last_of_run    = 1'b1;
              n_res               = 2'd1;
            end else begin
              // wrong index costs an attempt
              attempts_used_next = att_inc;
              tick_count_next    = 16'd0;
              if (exhausted) begin
                busy_next = 1'b0;
                res0      = fail_res;
                n_res     = 2'd1;
              end
            end
          end else if (item.rx_identifier == emcy_id) begin
            // emergency is reported, then may also end the transaction
            res0.result_kind    = KIND_EMCY;
            res0.emergency_code = item.rx_payload[15:0];
            res0.last_of_run    = !exhausted;
            attempts_used_next  = att_inc;
            tick_count_next     = 16'd0;
            n_res               = 2'd1;
            if (exhausted) begin
              busy_next = 1'b0;
              res1      = fail_res;
              n_res     = 2'd2;
            end
          end else begin
            // frames from other nodes are ignored
          end
        end
      end
      OP_TICK: begin
        if (busy) begin
          tick_count_next = tick_sat;
          if (tick_sat >= response_timeout) begin
            attempts_used_next = att_inc;
            tick_count_next    = 16'd0;
            if (exhausted) begin
              busy_next = 1'b0;
              res0      = fail_res;
              n_res     = 2'd1;
            end
          end
        end
      end
      default: begin
        // unused opcode, nothing happens
      end
    endcase
  end

  assign count_next = count + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};

  // control state, configuration and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      response_timeout <= TIMEOUT_RESET;
      max_attempts     <= ATTEMPTS_RESET;
      busy             <= 1'b0;
      pending_node     <= '0;
      pending_index    <= '0;
      attempts_used    <= '0;
      tick_count       <= '0;
      last_response    <= '0;
      rd_ptr           <= '0;
      wr_ptr           <= '0;
      count            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIMEOUT:  response_timeout <= cfg_data;
          REG_ATTEMPTS: max_attempts     <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (accept) begin
        busy          <= busy_next;
        pending_node  <= pending_node_next;
        pending_index <= pending_index_next;
        attempts_used <= attempts_used_next;
        tick_count    <= tick_count_next;
        last_response <= last_response_next;
        wr_ptr        <= wr_ptr + n_res;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

endmodule

[rtl/sdoc_checker.sv]
// port-level checker for the expedited sdo client, bound to the top level
// depends on sdoc_pkg and sdo_expedited_client_assert.svh
`include "sdo_expedited_client_assert.svh"

module sdoc_checker
  import sdoc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // nothing comes out the cycle after reset
  `SDOC_ASSERT_NEXT(a_reset_empty, clk, rst, !result_valid, "result beat right after reset")

  // a stalled result beat holds
  `SDOC_ASSERT_NEXT(a_stall_hold, clk, !rst && result_valid && !result_ready, result_valid && $stable(result), "stalled result beat changed")

  // a transmit frame is always the only result of its start
  `SDOC_ASSERT_RUN(a_tx_last, clk, rst, result_valid && result.result_kind == KIND_TX, result.last_of_run && result.response_value == 32'd0, "bad transmit beat")

  // emergency reports carry only the code
  `SDOC_ASSERT_RUN(a_emcy_clean, clk, rst, result_valid && result.result_kind == KIND_EMCY, result.frame_identifier == 11'd0 && result.frame_payload == 64'd0, "emergency beat carries frame data")

  // success and failure echo the upper response word
  `SDOC_ASSERT_RUN(a_resp_word, clk, rst, result_valid && (result.result_kind == KIND_OK || result.result_kind == KIND_FAIL), result.response_value == result.frame_payload[63:32] && result.frame_identifier == 11'd0, "response word mismatch")

endmodule

bind sdo_expedited_client sdoc_checker u_sdoc_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the expedited sdo client: directed beats, then random
// transactions under several timeout and attempt settings, checked in order
// depends on sdoc_pkg and the sdo_expedited_client top level
import sdoc_pkg::*;

// tracks the client's transaction state and holds the result beats it owes
class sdo_scoreboard;
  logic [15:0] timeout_ticks;
  logic [2:0]  attempt_limit;
  bit          busy;
  logic [6:0]  node;
  logic [15:0] index;
  logic [2:0]  attempts;
  logic [15:0] ticks;
  logic [63:0] last_rsp;
  result_t     owed_q[$];
  int          errors;

  function new();
    timeout_ticks = TIMEOUT_RESET;
    attempt_limit = ATTEMPTS_RESET;
    busy = 1'b0;
    node = '0;
    index = '0;
    attempts = '0;
    ticks = '0;
    last_rsp = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_TIMEOUT) timeout_ticks = data;
    else attempt_limit = data[2:0];
  endfunction

  function void owe(logic [1:0] kind, logic [10:0] id, logic [63:0] pay,
                    logic [31:0] val, logic [15:0] code, logic last);
    result_t r;
    r.result_kind = kind;
    r.frame_identifier = id;
    r.frame_payload = pay;
    r.response_value = val;
    r.emergency_code = code;
    r.last_of_run = last;
    owed_q.push_back(r);
  endfunction

  // one attempt gone; returns 1 when that ends the transaction in failure
  function bit take_attempt();
    attempts = attempts + 3'd1;
    ticks = '0;
    if (attempts >= attempt_limit) begin
      busy = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void owe_failure();
    logic [63:0] pay;
    pay = {last_rsp[63:8], 8'h00};
    owe(KIND_FAIL, '0, pay, pay[63:32], '0, 1'b1);
  endfunction

  // returns 1 when the beat changed state or caused a result
  function bit note(item_t it);
    bit gone;
    if (it.opcode == OP_START) begin
      if (busy) return 1'b0;
      busy = 1'b1;
      node = it.node_id;
      index = it.object_index;
      attempts = '0;
      ticks = '0;
      last_rsp = '0;
      owe(KIND_TX, REQ_BASE + node,
          {it.write_value, it.object_subindex, it.object_index, it.command_byte},
          '0, '0, 1'b1);
      return 1'b1;
    end
    if (it.opcode == OP_FRAME) begin
      if (!busy) return 1'b0;
      if (it.rx_identifier == RSP_BASE + node) begin
        last_rsp = it.rx_payload;
        if (it.rx_payload[23:8] == index) begin
          busy = 1'b0;
          ticks = '0;
          owe(KIND_OK, '0, it.rx_payload, it.rx_payload[63:32], '0, 1'b1);
        end else if (take_attempt()) begin
          owe_failure();
        end
        return 1'b1;
      end
      if (it.rx_identifier == EMCY_BASE + node) begin
        // the report comes first; a failure after it carries the last flag
        gone = take_attempt();
        owe(KIND_EMCY, '0, '0, '0, it.rx_payload[15:0], !gone);
        if (gone) owe_failure();
        return 1'b1;
      end
      return 1'b0;
    end
    if (it.opcode == OP_TICK) begin
      if (!busy) return 1'b0;
      if (ticks != TICK_MAX) ticks = ticks + 16'd1;
      if (ticks >= timeout_ticks && take_attempt()) owe_failure();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task check(result_t got);
    result_t want;
    if (owed_q.size() == 0) begin
      report($sformatf("result beat with nothing owed, kind %0d", got.result_kind));
      return;
    end
    want = owed_q.pop_front();
    if (got.result_kind !== want.result_kind)
      report($sformatf("result_kind %0h, want %0h", got.result_kind, want.result_kind));
    if (got.frame_identifier !== want.frame_identifier)
      report($sformatf("frame_identifier %0h, want %0h",
                       got.frame_identifier, want.frame_identifier));
    if (got.frame_payload !== want.frame_payload)
      report($sformatf("frame_payload %0h, want %0h",
                       got.frame_payload, want.frame_payload));
    if (got.response_value !== want.response_value)
      report($sformatf("response_value %0h, want %0h",
                       got.response_value, want.response_value));
    if (got.emergency_code !== want.emergency_code)
      report($sformatf("emergency_code %0h, want %0h",
                       got.emergency_code, want.emergency_code));
    if (got.last_of_run !== want.last_of_run)
      report($sformatf("last_of_run %0b, want %0b", got.last_of_run, want.last_of_run));
  endtask

  task wrap_up();
    if (owed_q.size() != 0)
      report($sformatf("%0d result beats never arrived", owed_q.size()));
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 1000000;
  // opcode the client has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   item_valid;
  logic                   item_ready;
  item_t                  item;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;

  sdo_scoreboard sb;
  int            cycles = 0;
  int            sent = 0;
  rx_mode_t      rx_mode = RX_OPEN;
  int            rx_left = 0;

  sdo_expedited_client u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check every taken beat, then pick next cycle's ready
  // from a stall pattern that is redrawn whenever its countdown runs out
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check(result);
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        result_ready <= 1'b1;
      end
      RX_COIN: begin
        result_ready <= 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        result_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        result_ready <= ~result_ready;
      end
    endcase
  end

  // every field but the opcode random, so unused fields toggle too
  function automatic item_t rand_item();
    item_t it;
    it.opcode = OP_TICK;
    it.node_id = 7'($urandom);
    it.command_byte = 8'($urandom);
    it.object_index = 16'($urandom);
    it.object_subindex = 8'($urandom);
    it.write_value = $urandom;
    it.rx_identifier = 11'($urandom);
    it.rx_payload = {$urandom, $urandom};
    return it;
  endfunction

  function automatic item_t mk_start(logic [6:0] nd, logic [7:0] cmd, logic [15:0] idx,
                                     logic [7:0] sub, logic [31:0] val);
    item_t it;
    it = rand_item();
    it.opcode = OP_START;
    it.node_id = nd;
    it.command_byte = cmd;
    it.object_index = idx;
    it.object_subindex = sub;
    it.write_value = val;
    return it;
  endfunction

  function automatic item_t mk_frame(logic [10:0] id, logic [63:0] pay);
    item_t it;
    it = rand_item();
    it.opcode = OP_FRAME;
    it.rx_identifier = id;
    it.rx_payload = pay;
    return it;
  endfunction

  function automatic item_t mk_op(logic [1:0] op);
    item_t it;
    it = rand_item();
    it.opcode = op;
    return it;
  endfunction

  // response from the pending node that carries the pending index
  function automatic item_t matching_rsp();
    item_t it;
    it = mk_frame(RSP_BASE + sb.node, {$urandom, $urandom});
    it.rx_payload[23:8] = sb.index;
    return it;
  endfunction

  // mostly well-formed traffic aimed at the pending node, plus noise
  function automatic item_t next_item(int tick_pct);
    item_t it;
    int    r;
    logic [10:0] base;
    it = rand_item();
    r = $urandom_range(0, 99);
    if (!sb.busy) begin
      if (r < 75) it.opcode = OP_START;
      else if (r < 85) it.opcode = OP_TICK;
      else if (r < 95) it = mk_frame(RSP_BASE + sb.node, {$urandom, $urandom});
      else it.opcode = OP_UNUSED;
      return it;
    end
    if (r < tick_pct) return mk_op(OP_TICK);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.opcode = OP_START;
    end else if (r < 40) begin
      it = matching_rsp();
    end else if (r < 58) begin
      it = mk_frame(RSP_BASE + sb.node, {$urandom, $urandom});
    end else if (r < 73) begin
      it = mk_frame(EMCY_BASE + sb.node, {$urandom, $urandom});
    end else if (r < 85) begin
      case ($urandom_range(0, 2))
        0: base = RSP_BASE;
        1: base = EMCY_BASE;
        default: base = REQ_BASE;
      endcase
      it = mk_frame(base + 11'($urandom_range(0, 127)), {$urandom, $urandom});
    end else if (r < 95) begin
      it.opcode = OP_FRAME;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // hold the beat until taken; valid stays up for a following beat
  task automatic send(input item_t it);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    void'(sb.note(it));
    sent++;
  endtask

  task automatic pause(input int n);
    item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every owed beat, then let beats that owe nothing go through
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // close any open transaction, let the block go quiet, then reconfigure
  task automatic reconfigure(input logic [15:0] timeout, input logic [2:0] limit);
    if (sb.busy) send(matching_rsp());
    drain();
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_ATTEMPTS, CFG_DATA_W'(limit));
  endtask

  task automatic run_phase(input logic [15:0] timeout, input logic [2:0] limit,
                           input int beats, input int tick_pct);
    int stop;
    reconfigure(timeout, limit);
    stop = sent + beats;
    while (sent < stop) begin
      repeat ($urandom_range(1, 20)) send(next_item(tick_pct));
      if ($urandom_range(0, 9) < 7) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_valid <= 1'b0;
    item <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: idle beats are dropped, a full transaction with noise
    send(mk_op(OP_TICK));
    send(mk_frame(RSP_BASE, '1));
    send(mk_op(OP_UNUSED));
    send(mk_start(7'd0, 8'h00, 16'h0000, 8'h00, 32'h0000_0000));
    send(mk_start(7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
    send(mk_frame(11'h7FF, '1));
    send(mk_frame(RSP_BASE, 64'hFFFF_FFFF_FFFF_FFFF));
    send(mk_frame(EMCY_BASE, 64'h0123_4567_89AB_CDEF));
    send(mk_op(OP_TICK));
    send(mk_frame(RSP_BASE, 64'h8765_4321_0000_0043));
    // extreme node and fields
    send(mk_start(7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
    send(mk_op(OP_UNUSED));
    send(mk_frame(EMCY_BASE + 11'h7F, 64'hFFFF_FFFF_FFFF_FFFF));
    send(mk_frame(RSP_BASE + 11'h7F, 64'hFFFF_FFFF_FFFF_FFFF));

    // short timeout and two attempts: timeout failure after a bad response
    reconfigure(16'd2, 3'd2);
    send(mk_start(7'd5, 8'h40, 16'h1234, 8'h01, 32'h0));
    send(mk_frame(RSP_BASE + 11'd5, 64'hAABB_CCDD_0056_7843));
    send(mk_op(OP_TICK));
    send(mk_op(OP_TICK));
    // emergency that exhausts the attempts gives report then failure
    send(mk_start(7'd9, 8'h23, 16'hBEEF, 8'h02, 32'hDEAD_BEEF));
    send(mk_frame(EMCY_BASE + 11'd9, 64'h0000_0000_0000_8130));
    send(mk_frame(EMCY_BASE + 11'd9, 64'hFFFF_FFFF_FFFF_5000));
    // timeout then mismatched response
    send(mk_start(7'd1, 8'h2B, 16'h6040, 8'h00, 32'h0000_000F));
    send(mk_op(OP_TICK));
    send(mk_op(OP_TICK));
    send(mk_frame(RSP_BASE + 11'd1, 64'h1122_3344_0060_4160));

    // random traffic across settings, extremes included
    run_phase(16'd0, 3'd0, 150, 20);
    run_phase(16'd1, 3'd1, 200, 25);
    run_phase(16'd3, 3'd7, 300, 45);
    run_phase(16'd4, 3'd3, 250, 40);
    run_phase(16'd7, 3'd5, 250, 70);
    run_phase(16'hFFFF, 3'd7, 150, 30);
    run_phase(TIMEOUT_RESET, ATTEMPTS_RESET, 150, 30);

    drain();
    repeat (10) @(posedge clk);
    sb.wrap_up();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
